@@ src/isc_pkg.sv @@
`timescale 1ns / 1ps

package isc_pkg;

    // Default store depth and coordinate width.
    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_WIDTH    = 2;
    localparam int FIELD_WIDTH  = 32;
    localparam int HIT_WIDTH    = 11;
    localparam logic [HIT_WIDTH-1:0] HIT_MAX = '1;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic scan_issue;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/isc_ctrl.sv @@
`timescale 1ns / 1ps

module isc_ctrl
    import isc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [CMD_WIDTH-1:0] command,
    input  dp_stat_t             stat,
    output logic                 busy,
    output ctrl_cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.load_out   = 1'b0;
        busy           = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    // A query over an empty store has nothing to scan.
                    if ((command == CMD_QUERY) && !stat.count_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/isc_datapath.sv @@
`timescale 1ns / 1ps

module isc_datapath
    import isc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    input  logic [CMD_WIDTH-1:0]   command,
    input  logic [FIELD_WIDTH-1:0] seg_left,
    input  logic [FIELD_WIDTH-1:0] seg_right,
    input  logic [FIELD_WIDTH-1:0] point,
    input  logic                   out_stall,
    output dp_stat_t               stat,
    output logic                   out_valid,
    output logic [HIT_WIDTH-1:0]   hit_count,
    output logic                   status
);

    localparam int ADDR_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTRY_W = 2 * COORD_WIDTH;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEGMENTS);

    logic [ENTRY_W-1:0] mem [MAX_SEGMENTS];

    logic [CNT_W-1:0]              seg_count_reg;
    logic [ADDR_W-1:0]             rd_addr_reg;
    logic [ADDR_W-1:0]             last_addr_reg;
    logic signed [COORD_WIDTH-1:0] point_reg;
    logic [ENTRY_W-1:0]            rd_data_reg;
    logic                          rd_vld_reg;
    logic                          match_reg;
    logic                          match_next;
    logic [HIT_WIDTH-1:0]          hits_reg;
    logic                          res_status_reg;
    logic                          out_valid_reg;
    logic [HIT_WIDTH-1:0]          hit_count_reg;
    logic                          status_reg;

    logic                          full;
    logic                          wr_en;
    logic signed [COORD_WIDTH-1:0] rd_lo;
    logic signed [COORD_WIDTH-1:0] rd_hi;

    assign full  = (seg_count_reg == CNT_FULL);
    assign wr_en = cmd.take && (cmd_t'(command) == CMD_ADD) && !full;

    assign rd_lo = $signed(rd_data_reg[COORD_WIDTH-1:0]);
    assign rd_hi = $signed(rd_data_reg[ENTRY_W-1:COORD_WIDTH]);

    assign match_next = rd_vld_reg && (point_reg >= rd_lo) && (point_reg <= rd_hi);

    assign stat.count_zero = (seg_count_reg == '0);
    assign stat.scan_last  = (rd_addr_reg == last_addr_reg);
    assign stat.pipe_empty = !rd_vld_reg && !match_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Segment store: one write port for adds, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[seg_count_reg[ADDR_W-1:0]] <= {seg_right[COORD_WIDTH-1:0],
                                               seg_left[COORD_WIDTH-1:0]};
        end
        if (cmd.scan_issue)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    // Per-item payload captured when the beat is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            point_reg     <= $signed(point[COORD_WIDTH-1:0]);
            last_addr_reg <= ADDR_W'(seg_count_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg  <= '0;
            rd_addr_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            match_reg      <= 1'b0;
            hits_reg       <= '0;
            res_status_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_issue;
            match_reg  <= match_next;
            if (cmd.take)
            begin
                hits_reg       <= '0;
                res_status_reg <= 1'b0;
                rd_addr_reg    <= '0;
                case (cmd_t'(command))
                    CMD_CLEAR:
                    begin
                        seg_count_reg <= '0;
                    end
                    CMD_ADD:
                    begin
                        if (full)
                        begin
                            res_status_reg <= 1'b1;
                        end
                        else
                        begin
                            seg_count_reg <= seg_count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                end
                // The count sticks at its top value on a very deep store.
                if (match_reg && (hits_reg != HIT_MAX))
                begin
                    hits_reg <= hits_reg + HIT_WIDTH'(1);
                end
            end
        end
    end

    // Output register: the next item may be taken while this beat waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            hit_count_reg <= hits_reg;
            status_reg    <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_count = hit_count_reg;
    assign status    = status_reg;

endmodule

@@ src/interval_stabbing_counter_unit.sv @@
`timescale 1ns / 1ps
// Clear, add, unused commands and a query over an empty store go from the idle state
// straight to the done state, which loads the result into the output register.
// A query over n stored segments scans them through the single read port of the segment
// store, which is read once per cycle, then drains the compare pipeline before the done
// state; the input stays stalled until the result is loaded into the output register.
// Asynchronous active-low reset empties the store (count to zero) and leaves no beat pending.
module interval_stabbing_counter_unit
    import isc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_WIDTH-1:0]   command,
    input  logic [FIELD_WIDTH-1:0] seg_left,
    input  logic [FIELD_WIDTH-1:0] seg_right,
    input  logic [FIELD_WIDTH-1:0] point,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HIT_WIDTH-1:0]   hit_count,
    output logic                   status
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    isc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (dp_stat),
        .busy     (in_stall),
        .cmd      (ctrl_cmd)
    );

    isc_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .command   (command),
        .seg_left  (seg_left),
        .seg_right (seg_right),
        .point     (point),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .out_valid (out_valid),
        .hit_count (hit_count),
        .status    (status)
    );

    // Only one item is processed at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input beat taken while an item is still in progress");

    // The scan pipeline has drained whenever a new item may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> dp_stat.pipe_empty)
        else $error("scan pipeline busy while the block is idle");

    // A rejected add never carries a hit count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (hit_count == '0))
        else $error("full status reported with a non-zero hit count");

    // The output slot is never loaded over a beat that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.load_out) |-> (!out_valid || !out_stall))
        else $error("result loaded over a stalled output beat");

endmodule
